// ===== rtl/core/hvn_pkg.sv =====
// ---------------------------------------------------------------------------
// Heightmap vertex normals package
// Shared types and fixed widths for the vertex normal generator.
// ---------------------------------------------------------------------------
`default_nettype none

package hvn_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_MAP_WIDTH      = 2'd0,
    REG_MAP_HEIGHT     = 2'd1,
    REG_HEIGHT_DIVISOR = 2'd2
  } reg_index_e;

  // A face sum component lies within +/-1020 (four faces of 8-bit differences).
  localparam int unsigned SumW  = 12;
  // Squared length of a face sum, at most 3 * 1020^2.
  localparam int unsigned LenW  = 22;
  // Root of the length shifted up by 28 bits.
  localparam int unsigned RootW = 25;
  // Partial remainder of the shared subtract unit.
  localparam int unsigned RemW  = 28;
  // Quotient bits of one component division.
  localparam int unsigned QuotW = 16;

  localparam int unsigned SqrtSteps = 25;
  localparam int unsigned DivSteps  = 16;
  localparam int unsigned LenShift  = 28;
  localparam int unsigned MagShift  = 12;

  localparam logic [QuotW-1:0] NormOne = 16'd16384;

  typedef logic signed [SumW-1:0] sum_t;
  typedef logic [7:0]             sample_t;

endpackage

`default_nettype wire

// ===== rtl/core/heightmap_vertex_normals.sv =====
// ---------------------------------------------------------------------------
// Heightmap vertex normals
// Streams height samples in and unit vertex normals in signed Q1.14 out.
// ---------------------------------------------------------------------------
// Usage: height samples arrive in row-major order on the input channel
// (in_valid_i, in_stall_o, height_sample_i). The last three rows are kept
// in an internal line store. When sample (c,r) is accepted the normal of
// vertex (c,r-1) is produced, and on the last row also that of vertex
// (c,r); end_of_item_o marks the last word caused by a sample and
// end_of_map_o marks the final vertex of the map.
// Each word is a full set of normal components plus the vertex position,
// and leaves through a single output register (out_valid_o, out_stall_i).
// Sequence: a sample is written and its 3 x 3 window fetched, then each
// normal takes one sum, the squaring of three components, 25 root steps,
// three loads and 48 division steps and one output load. A sample of the
// first row is only written. A single 28-bit compare and subtract unit
// performs every root and division step. The block takes no new sample
// while a sample is at work or a configuration word is offered, takes
// configuration words only while idle, and waits in place while the
// receiver stalls.
// Reset clears the row and column counters, sets width and height to 256
// and the divisor to 15; a size write also restarts the map.
// ---------------------------------------------------------------------------
`default_nettype none

module heightmap_vertex_normals #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration write channel.
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [12:0]        cfg_data_i,
  // Sample input channel.
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         height_sample_i,
  // Normal output channel.
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      normal_x_o,
  output logic signed [15:0]      normal_y_o,
  output logic signed [15:0]      normal_z_o,
  output logic [11:0]             vertex_row_o,
  output logic [9:0]              vertex_column_o,
  output logic                    end_of_item_o,
  output logic                    end_of_map_o
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned WXW   = (CW > 11) ? CW : 11;
  localparam int unsigned HXW   = (RW > 13) ? RW : 13;
  localparam int unsigned Depth = 3 * MAX_WIDTH;
  localparam int unsigned AW    = $clog2(Depth);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_SQUARE,
    ST_SQRT,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [10:0] map_width_q;
  logic [12:0] map_height_q;
  logic [7:0]  height_divisor_q;

  // Map position counters.
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [1:0]    slot_q;

  // Context of the sample at work.
  logic [CW-1:0] cur_c_q;
  logic [RW-1:0] cur_r_q;
  logic [1:0]    cur_slot_q;
  logic          emit_a_q;
  logic          emit_b_q;
  logic          vtx_q;

  // Window fetch.
  logic [3:0]           rd_k_q;
  logic [1:0]           rd_r_q;
  logic [1:0]           rd_c_q;
  hvn_pkg::sample_t     win_q [9];
  hvn_pkg::sample_t     row_store [Depth];
  hvn_pkg::sample_t     rdata_q;
  logic [AW-1:0]        raddr;
  logic [AW-1:0]        waddr;

  // Arithmetic state.
  hvn_pkg::sum_t                sum_q [3];
  logic [hvn_pkg::LenW-1:0]     len_q;
  logic [49:0]                  v_q;
  logic [hvn_pkg::RootW-1:0]    root_q;
  logic [hvn_pkg::RemW-1:0]     rem_q;
  logic [hvn_pkg::QuotW-1:0]    quot_q;
  logic [4:0]                   step_q;
  logic [1:0]                   comp_q;
  logic signed [15:0]           norm_q [3];

  logic signed [15:0] normal_x_q, normal_y_q, normal_z_q;
  logic [11:0]        vertex_row_q;
  logic [9:0]         vertex_column_q;
  logic               end_of_item_q, end_of_map_q, out_valid_q;

  // Effective (clamped) map size.
  logic [WXW-1:0] w_raw;
  logic [HXW-1:0] h_raw;
  logic [CW-1:0]  w_eff;
  logic [RW-1:0]  h_eff;

  always_comb begin
    w_raw = WXW'(map_width_q);
    h_raw = HXW'(map_height_q);
    if (w_raw < WXW'(2)) begin
      w_eff = CW'(2);
    end else if (w_raw > WXW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(w_raw);
    end
    if (h_raw < HXW'(2)) begin
      h_eff = RW'(2);
    end else if (h_raw > HXW'(MAX_HEIGHT)) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(h_raw);
    end
  end

  // Position of the incoming sample; a stale position restarts the map.
  logic          in_accept;
  logic          cfg_accept;
  logic          pos_wrap;
  logic [CW-1:0] acc_c;
  logic [RW-1:0] acc_r;
  logic [1:0]    acc_slot;

  // A configuration word offered while idle goes first, so a sample and a
  // register write never land on the same edge.
  assign in_stall_o  = (state_q != ST_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_accept  = cfg_valid_i && cfg_ready_o;
  assign pos_wrap    = (col_q >= w_eff) || (row_q >= h_eff);
  assign acc_c       = pos_wrap ? '0 : col_q;
  assign acc_r       = pos_wrap ? '0 : row_q;
  assign acc_slot    = pos_wrap ? 2'd0 : slot_q;

  function automatic logic [1:0] slot_back(input logic [1:0] s, input logic [1:0] n);
    logic [1:0] t;
    t = s;
    if (n >= 2'd1) t = (t == 2'd0) ? 2'd2 : t - 2'd1;
    if (n == 2'd2) t = (t == 2'd0) ? 2'd2 : t - 2'd1;
    return t;
  endfunction

  // Line store addressing. Window row 0 is row r-2, row 2 is row r.
  logic [CW:0]   rd_col_sum;
  logic [CW:0]   rd_col;
  logic [1:0]    rd_slot;

  always_comb begin
    rd_col_sum = (CW+1)'(cur_c_q) + (CW+1)'(rd_c_q);
    rd_col     = rd_col_sum - (CW+1)'(1);
    if (rd_col_sum == '0 || rd_col >= (CW+1)'(MAX_WIDTH)) begin
      rd_col = '0;
    end
    rd_slot = slot_back(cur_slot_q, 2'd2 - rd_r_q);
    raddr   = AW'(rd_slot) * AW'(MAX_WIDTH) + AW'(rd_col);
    waddr   = AW'(acc_slot) * AW'(MAX_WIDTH) + AW'(acc_c);
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      row_store[waddr] <= height_sample_i;
    end
    rdata_q <= row_store[raddr];
  end

  // Face sums of the current vertex from the window.
  hvn_pkg::sample_t t0, t1, t2, m0, m1, m2, b0, b1;
  logic             up, down, left, right;
  hvn_pkg::sum_t    fx, fy, fz, dval;

  always_comb begin
    t0 = vtx_q ? win_q[3] : win_q[0];
    t1 = vtx_q ? win_q[4] : win_q[1];
    t2 = vtx_q ? win_q[5] : win_q[2];
    m0 = vtx_q ? win_q[6] : win_q[3];
    m1 = vtx_q ? win_q[7] : win_q[4];
    m2 = vtx_q ? win_q[8] : win_q[5];
    b0 = win_q[6];
    b1 = win_q[7];
    up    = vtx_q ? 1'b1 : (cur_r_q >= RW'(2));
    down  = !vtx_q;
    left  = (cur_c_q != '0);
    right = ((CW+1)'(cur_c_q) + (CW+1)'(1)) < (CW+1)'(w_eff);
    dval  = (height_divisor_q == 8'd0) ? hvn_pkg::sum_t'(1)
                                       : hvn_pkg::sum_t'(height_divisor_q);
    fx = '0;
    fy = '0;
    fz = '0;
    if (up && left) begin
      fx = fx + hvn_pkg::sum_t'(t0) - hvn_pkg::sum_t'(t1);
      fz = fz + hvn_pkg::sum_t'(t0) - hvn_pkg::sum_t'(m0);
      fy = fy + dval;
    end
    if (up && right) begin
      fx = fx + hvn_pkg::sum_t'(t1) - hvn_pkg::sum_t'(t2);
      fz = fz + hvn_pkg::sum_t'(t1) - hvn_pkg::sum_t'(m1);
      fy = fy + dval;
    end
    if (down && left) begin
      fx = fx + hvn_pkg::sum_t'(m0) - hvn_pkg::sum_t'(m1);
      fz = fz + hvn_pkg::sum_t'(m0) - hvn_pkg::sum_t'(b0);
      fy = fy + dval;
    end
    if (down && right) begin
      fx = fx + hvn_pkg::sum_t'(m1) - hvn_pkg::sum_t'(m2);
      fz = fz + hvn_pkg::sum_t'(m1) - hvn_pkg::sum_t'(b1);
      fy = fy + dval;
    end
  end

  // Squaring multiplier, one component per cycle.
  hvn_pkg::sum_t      sq_in;
  logic signed [23:0] sq_prod;

  assign sq_in   = sum_q[comp_q];
  assign sq_prod = sq_in * sq_in;

  // Magnitude and sign of the component being divided.
  logic                      comp_neg;
  logic [hvn_pkg::SumW-2:0]  comp_mag;

  assign comp_neg = sq_in[hvn_pkg::SumW-1];
  assign comp_mag = comp_neg ? (hvn_pkg::SumW-1)'(-sq_in) : (hvn_pkg::SumW-1)'(sq_in);

  // The shared compare and subtract unit: root steps and division steps.
  logic [hvn_pkg::RemW-1:0] alu_a, alu_b;
  logic [hvn_pkg::RemW:0]   alu_diff;
  logic                     alu_ge;

  always_comb begin
    if (state_q == ST_SQRT) begin
      alu_a = {rem_q[hvn_pkg::RemW-3:0], v_q[49:48]};
      alu_b = {1'b0, root_q, 2'b01};
    end else begin
      alu_a = {rem_q[hvn_pkg::RemW-2:0], 1'b0};
      alu_b = hvn_pkg::RemW'(root_q);
    end
    alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
    alu_ge   = !alu_diff[hvn_pkg::RemW];
  end

  // Final quotient of a division step, clamped and signed.
  logic [hvn_pkg::QuotW-1:0] quot_next;
  logic [hvn_pkg::QuotW-1:0] quot_clamp;
  logic signed [15:0]        norm_val;

  always_comb begin
    quot_next  = {quot_q[hvn_pkg::QuotW-2:0], alu_ge};
    quot_clamp = (quot_next > hvn_pkg::NormOne) ? hvn_pkg::NormOne : quot_next;
    norm_val   = comp_neg ? -$signed(quot_clamp) : $signed(quot_clamp);
  end

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      map_width_q      <= 11'd256;
      map_height_q     <= 13'd256;
      height_divisor_q <= 8'd15;
      col_q            <= '0;
      row_q            <= '0;
      slot_q           <= 2'd0;
      cur_c_q          <= '0;
      cur_r_q          <= '0;
      cur_slot_q       <= 2'd0;
      emit_a_q         <= 1'b0;
      emit_b_q         <= 1'b0;
      vtx_q            <= 1'b0;
      rd_k_q           <= '0;
      rd_r_q           <= '0;
      rd_c_q           <= '0;
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
      for (int k = 0; k < 3; k++) begin
        sum_q[k]  <= '0;
        norm_q[k] <= '0;
      end
      len_q            <= '0;
      v_q              <= '0;
      root_q           <= '0;
      rem_q            <= '0;
      quot_q           <= '0;
      step_q           <= '0;
      comp_q           <= '0;
      normal_x_q       <= '0;
      normal_y_q       <= '0;
      normal_z_q       <= '0;
      vertex_row_q     <= '0;
      vertex_column_q  <= '0;
      end_of_item_q    <= 1'b0;
      end_of_map_q     <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_accept) begin
        unique case (cfg_index_i)
          hvn_pkg::REG_MAP_WIDTH: begin
            map_width_q <= cfg_data_i[10:0];
            col_q       <= '0;
            row_q       <= '0;
            slot_q      <= 2'd0;
          end
          hvn_pkg::REG_MAP_HEIGHT: begin
            map_height_q <= cfg_data_i;
            col_q        <= '0;
            row_q        <= '0;
            slot_q       <= 2'd0;
          end
          hvn_pkg::REG_HEIGHT_DIVISOR: begin
            height_divisor_q <= cfg_data_i[7:0];
          end
          default: begin
          end
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            cur_c_q    <= acc_c;
            cur_r_q    <= acc_r;
            cur_slot_q <= acc_slot;
            emit_a_q   <= (acc_r != '0);
            emit_b_q   <= ((RW+1)'(acc_r) + (RW+1)'(1)) == (RW+1)'(h_eff);
            vtx_q      <= (acc_r == '0);
            rd_k_q     <= '0;
            rd_r_q     <= '0;
            rd_c_q     <= '0;
            // Advance the map position.
            if ((CW+1)'(acc_c) + (CW+1)'(1) >= (CW+1)'(w_eff)) begin
              col_q <= '0;
              if ((RW+1)'(acc_r) + (RW+1)'(1) >= (RW+1)'(h_eff)) begin
                row_q  <= '0;
                slot_q <= 2'd0;
              end else begin
                row_q  <= acc_r + RW'(1);
                slot_q <= (acc_slot == 2'd2) ? 2'd0 : acc_slot + 2'd1;
              end
            end else begin
              col_q  <= acc_c + CW'(1);
              row_q  <= acc_r;
              slot_q <= acc_slot;
            end
            // The first row of a map yields nothing (height is at least two).
            if (acc_r != '0) begin
              state_q <= ST_READ;
            end
          end
        end

        ST_READ: begin
          if (rd_k_q != 4'd0) begin
            win_q[rd_k_q - 4'd1] <= rdata_q;
          end
          if (rd_c_q == 2'd2) begin
            rd_c_q <= 2'd0;
            rd_r_q <= rd_r_q + 2'd1;
          end else begin
            rd_c_q <= rd_c_q + 2'd1;
          end
          rd_k_q <= rd_k_q + 4'd1;
          if (rd_k_q == 4'd9) begin
            state_q <= ST_SUM;
          end
        end

        ST_SUM: begin
          sum_q[0] <= fx;
          sum_q[1] <= fy;
          sum_q[2] <= fz;
          len_q    <= '0;
          comp_q   <= 2'd0;
          state_q  <= ST_SQUARE;
        end

        ST_SQUARE: begin
          if (comp_q == 2'd2) begin
            v_q     <= {len_q + hvn_pkg::LenW'(sq_prod), (hvn_pkg::LenShift)'(0)};
            root_q  <= '0;
            rem_q   <= '0;
            step_q  <= '0;
            comp_q  <= 2'd0;
            state_q <= ST_SQRT;
          end else begin
            len_q  <= len_q + hvn_pkg::LenW'(sq_prod);
            comp_q <= comp_q + 2'd1;
          end
        end

        ST_SQRT: begin
          // One root digit a step: bring down two bits and try to subtract.
          v_q <= {v_q[47:0], 2'b00};
          if (alu_ge) begin
            rem_q  <= alu_diff[hvn_pkg::RemW-1:0];
            root_q <= {root_q[hvn_pkg::RootW-2:0], 1'b1};
          end else begin
            rem_q  <= alu_a;
            root_q <= {root_q[hvn_pkg::RootW-2:0], 1'b0};
          end
          if (step_q == 5'(hvn_pkg::SqrtSteps - 1)) begin
            step_q  <= '0;
            comp_q  <= 2'd0;
            quot_q  <= '0;
            state_q <= ST_DIV;
          end else begin
            step_q <= step_q + 5'd1;
          end
        end

        ST_DIV: begin
          if (step_q == 5'd0) begin
            // Load the shifted magnitude; the first quotient bit follows next.
            rem_q  <= hvn_pkg::RemW'(comp_mag) << hvn_pkg::MagShift;
            quot_q <= '0;
            step_q <= 5'd1;
          end else begin
            rem_q  <= alu_ge ? alu_diff[hvn_pkg::RemW-1:0] : alu_a;
            quot_q <= quot_next;
            if (step_q == 5'(hvn_pkg::DivSteps)) begin
              norm_q[comp_q] <= norm_val;
              step_q         <= '0;
              if (comp_q == 2'd2) begin
                state_q <= ST_OUT;
              end else begin
                comp_q <= comp_q + 2'd1;
              end
            end else begin
              step_q <= step_q + 5'd1;
            end
          end
        end

        ST_OUT: begin
          if (out_free) begin
            normal_x_q      <= norm_q[0];
            normal_y_q      <= norm_q[1];
            normal_z_q      <= norm_q[2];
            vertex_column_q <= 10'(cur_c_q);
            if (vtx_q) begin
              vertex_row_q <= 12'(cur_r_q);
              end_of_map_q <= ((CW+1)'(cur_c_q) + (CW+1)'(1)) == (CW+1)'(w_eff);
            end else begin
              vertex_row_q <= 12'(cur_r_q - RW'(1));
              end_of_map_q <= 1'b0;
            end
            end_of_item_q <= vtx_q || !emit_b_q;
            if (!vtx_q && emit_b_q) begin
              vtx_q   <= 1'b1;
              state_q <= ST_SUM;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      // Marks the normal as that of vertex (c,r) when a sample yields no normal of vertex (c,r-1).
      if (state_q == ST_SUM && !emit_a_q) begin
        vtx_q <= 1'b1;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign normal_x_o      = normal_x_q;
  assign normal_y_o      = normal_y_q;
  assign normal_z_o      = normal_z_q;
  assign vertex_row_o    = vertex_row_q;
  assign vertex_column_o = vertex_column_q;
  assign end_of_item_o   = end_of_item_q;
  assign end_of_map_o    = end_of_map_q;

endmodule

`default_nettype wire
